@@ hdl/tarpm_pkg.sv @@
// Shared types and constants for the three-axis rate PID mixer.
// Holds the register index codes, fixed-point constants and the
// command/status structs that join the controller and the datapath.
package tarpm_pkg;

   localparam int TARPM_AXES = 3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 48;
   localparam int AXIS_W      = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PULSE_CENTER = 3'd0,
      CSR_GAIN_PROP    = 3'd1,
      CSR_GAIN_INTEG   = 3'd2,
      CSR_GAIN_DERIV   = 3'd3,
      CSR_DRIVE_LIMIT  = 3'd4
   } csr_index_type;

   localparam logic [11:0] CENTER_RESET = 12'd1500;
   localparam logic [14:0] LIMIT_RESET  = 15'd400;

   localparam logic [AXIS_W-1:0] AXIS_ROLL = 2'd0;

   // floor(n/5) and floor(n/3) by reciprocal, offsets keep the dividend positive
   localparam logic signed [27:0] OFF5  = 28'sd41943040;  // 5 * 2^23
   localparam logic signed [27:0] OFF3  = 28'sd50331648;  // 3 * 2^24
   localparam logic signed [29:0] RCP5  = 30'sd214748365; // ceil(2^30 / 5)
   localparam logic signed [29:0] RCP3  = 30'sd357913942; // ceil(2^30 / 3)
   localparam logic signed [25:0] BASE5 = 26'sd8388608;   // 2^23
   localparam logic signed [26:0] BASE3 = 27'sd16777216;  // 2^24

   localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] Q_MIN = 24'sh800000;

   typedef struct packed {
      logic capture;
      logic div5;
      logic div3;
      logic err;
      logic mul_i;
      logic mul_p;
      logic mul_d;
      logic sum;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ hdl/tarpm_ctrl.sv @@
// Sequencer for the three-axis rate PID mixer.
// Steps one request through the datapath; uses tarpm_pkg command/status types.
module tarpm_ctrl import tarpm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_DIV5 = 9'b000000010,
      ST_DIV3 = 9'b000000100,
      ST_ERR  = 9'b000001000,
      ST_MULI = 9'b000010000,
      ST_MULP = 9'b000100000,
      ST_MULD = 9'b001000000,
      ST_SUM  = 9'b010000000,
      ST_FIN  = 9'b100000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_DIV5;
         end
         ST_DIV5: begin
            cmd.div5 = 1'b1;
            state_in = ST_DIV3;
         end
         ST_DIV3: begin
            cmd.div3 = 1'b1;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_MULI;
         end
         ST_MULI: begin
            cmd.mul_i = 1'b1;
            state_in  = ST_MULP;
         end
         ST_MULP: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_MULD;
         end
         ST_MULD: begin
            cmd.mul_d = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin = status.out_free;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ hdl/tarpm_datapath.sv @@
// Datapath of the three-axis rate PID mixer: config registers, per-axis state,
// one shared multiplier and the result register. Uses tarpm_pkg.
module tarpm_datapath import tarpm_pkg::*; #(
   parameter int AXES = TARPM_AXES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [AXIS_W-1:0]      req_tuser,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [AXIS_W-1:0]      rsp_tuser
);

   localparam int AIW = (AXES > 1) ? $clog2(AXES) : 1;

   // configuration
   logic [11:0] center_ff, center_in;
   logic [15:0] gprop_ff, gprop_in;
   logic [15:0] ginteg_ff, ginteg_in;
   logic [15:0] gderiv_ff, gderiv_in;
   logic [14:0] limit_ff, limit_in;

   // per-axis state
   logic signed [23:0] filt_ff [AXES];
   logic signed [23:0] integ_ff [AXES];
   logic signed [23:0] prev_ff [AXES];

   // request fields
   logic [AXIS_W-1:0] axis_req;
   logic [15:0]       gyro_req;
   logic [11:0]       stick_req;
   logic [15:0]       lc_req;

   // work registers
   logic [AXIS_W-1:0]  axis_ff, axis_in;
   logic [11:0]        stick_ff, stick_in;
   logic               valid_ff, valid_in;
   logic [AIW-1:0]     idx_ff, idx_in;
   logic signed [27:0] u5_ff, u5_in;
   logic signed [27:0] u3_ff, u3_in;
   logic signed [57:0] prod_ff, prod_in;
   logic signed [23:0] fnew_ff, fnew_in;
   logic signed [23:0] err_ff, err_in;
   logic signed [24:0] diff_ff, diff_in;
   logic signed [23:0] imem_ff, imem_in;
   logic signed [29:0] pp_ff, pp_in;
   logic signed [15:0] drive_ff, drive_in;

   // result register
   logic               rvalid_ff, rvalid_in;
   logic [AXIS_W-1:0]  raxis_ff, raxis_in;
   logic signed [15:0] rdrive_ff, rdrive_in;
   logic [12:0]        rservo_ff, rservo_in;
   logic [12:0]        rmirror_ff, rmirror_in;

   // combinational helpers
   logic               axis_ok;
   logic [AIW-1:0]     idx_cap;
   logic signed [23:0] f_rd;
   logic signed [23:0] x_q;
   logic signed [13:0] stick_s, c_s, d_v;
   logic signed [17:0] dl;
   logic signed [27:0] mul_a;
   logic signed [29:0] mul_b;
   logic signed [25:0] f_w;
   logic signed [26:0] q3_s, sp_w, e_w;
   logic signed [57:0] rnd_w;
   logic signed [29:0] rnd_v;
   logic signed [23:0] lim_q;
   logic signed [30:0] im_sum;
   logic signed [31:0] o_sum;
   logic signed [23:0] o_v, o_adj;
   logic signed [15:0] drv;
   logic signed [17:0] servo_w;
   logic signed [14:0] mirror_w;
   logic [12:0]        servo_v;

   assign axis_req  = req_tuser;
   assign gyro_req  = req_tdata[15:0];
   assign stick_req = req_tdata[27:16];
   assign lc_req    = req_tdata[43:28];

   always_comb begin
      center_in = center_ff;
      gprop_in  = gprop_ff;
      ginteg_in = ginteg_ff;
      gderiv_in = gderiv_ff;
      limit_in  = limit_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_PULSE_CENTER: center_in = csr_wdata[11:0];
            CSR_GAIN_PROP:    gprop_in  = csr_wdata;
            CSR_GAIN_INTEG:   ginteg_in = csr_wdata;
            CSR_GAIN_DERIV:   gderiv_in = csr_wdata;
            CSR_DRIVE_LIMIT:  limit_in  = csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // capture: filter dividend and setpoint dividend
   always_comb begin
      axis_ok = (32'(axis_req) < AXES);
      idx_cap = axis_ok ? AIW'(axis_req) : '0;
      f_rd    = filt_ff[idx_cap];
      x_q     = signed'({gyro_req, 8'h00});
      u5_in   = u5_ff;
      u3_in   = u3_ff;
      axis_in = axis_ff;
      stick_in = stick_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      stick_s = signed'({2'b00, stick_req});
      c_s     = signed'({2'b00, center_ff});
      if (stick_s > c_s + 14'sd8)      d_v = stick_s - (c_s + 14'sd8);
      else if (stick_s < c_s - 14'sd8) d_v = stick_s - (c_s - 14'sd8);
      else                             d_v = '0;
      dl = 18'(d_v) - 18'(signed'(lc_req));
      if (cmd.capture) begin
         axis_in  = axis_req;
         stick_in = stick_req;
         valid_in = axis_ok;
         idx_in   = idx_cap;
         u5_in    = (28'(f_rd) <<< 2) + 28'(x_q) + 28'sd2 + OFF5;
         u3_in    = (28'(dl) <<< 8) + 28'sd1 + OFF3;
      end
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.div5) begin
         mul_a = u5_ff;
         mul_b = RCP5;
      end else if (cmd.div3) begin
         mul_a = u3_ff;
         mul_b = RCP3;
      end else if (cmd.mul_i) begin
         mul_a = 28'(err_ff);
         mul_b = signed'({14'b0, ginteg_ff});
      end else if (cmd.mul_p) begin
         mul_a = 28'(err_ff);
         mul_b = signed'({14'b0, gprop_ff});
      end else if (cmd.mul_d) begin
         mul_a = 28'(diff_ff);
         mul_b = signed'({14'b0, gderiv_ff});
      end
      prod_in = (cmd.div5 || cmd.div3 || cmd.mul_i || cmd.mul_p || cmd.mul_d)
                ? mul_a * mul_b : prod_ff;
   end

   // filter, error, PID terms
   always_comb begin
      f_w   = signed'({1'b0, prod_ff[54:30]}) - BASE5;
      q3_s  = signed'({1'b0, prod_ff[55:30]});
      sp_w  = q3_s - BASE3;
      e_w   = 27'(fnew_ff) - sp_w;
      rnd_w = prod_ff + 58'sd2048;
      rnd_v = rnd_w[41:12];
      lim_q = signed'({1'b0, limit_ff, 8'h00});
      im_sum = 31'(integ_ff[idx_ff]) + 31'(rnd_v);
      o_sum  = 32'(pp_ff) + 32'(imem_ff) + 32'(rnd_v);

      fnew_in = fnew_ff;
      if (cmd.div3) begin
         if (f_w > 26'(Q_MAX))      fnew_in = Q_MAX;
         else if (f_w < 26'(Q_MIN)) fnew_in = Q_MIN;
         else                       fnew_in = f_w[23:0];
      end

      err_in = err_ff;
      if (cmd.err) begin
         if (e_w > 27'(Q_MAX))      err_in = Q_MAX;
         else if (e_w < 27'(Q_MIN)) err_in = Q_MIN;
         else                       err_in = e_w[23:0];
      end

      diff_in = cmd.mul_i ? 25'(err_ff) - 25'(prev_ff[idx_ff]) : diff_ff;

      imem_in = imem_ff;
      if (cmd.mul_p) begin
         if (im_sum > 31'(lim_q))       imem_in = lim_q;
         else if (im_sum < -31'(lim_q)) imem_in = -lim_q;
         else                           imem_in = im_sum[23:0];
      end

      pp_in = cmd.mul_d ? rnd_v : pp_ff;

      if (o_sum > 32'(lim_q))       o_v = lim_q;
      else if (o_sum < -32'(lim_q)) o_v = -lim_q;
      else                          o_v = o_sum[23:0];
      o_adj    = o_v[23] ? o_v + 24'sd255 : o_v;
      drive_in = cmd.sum ? o_adj[23:8] : drive_ff;
   end

   // result
   always_comb begin
      drv     = valid_ff ? drive_ff : '0;
      servo_w = signed'({6'b0, stick_ff}) + 18'(drv);
      if (servo_w < 18'sd0)         servo_v = '0;
      else if (servo_w > 18'sd8191) servo_v = 13'h1FFF;
      else                          servo_v = servo_w[12:0];
      mirror_w = signed'({2'b0, center_ff, 1'b0}) - signed'({2'b0, servo_v});

      rvalid_in  = rvalid_ff && !rsp_tready;
      raxis_in   = raxis_ff;
      rdrive_in  = rdrive_ff;
      rservo_in  = rservo_ff;
      rmirror_in = rmirror_ff;
      if (cmd.fin) begin
         rvalid_in = 1'b1;
         raxis_in  = axis_ff;
         rdrive_in = drv;
         rservo_in = servo_v;
         if (axis_ff != AXIS_ROLL)      rmirror_in = '0;
         else if (mirror_w < 15'sd0)    rmirror_in = '0;
         else if (mirror_w > 15'sd8191) rmirror_in = 13'h1FFF;
         else                           rmirror_in = mirror_w[12:0];
      end
   end

   assign status.out_free = !rvalid_ff || rsp_tready;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = raxis_ff;
   assign rsp_tdata  = {6'b0, rmirror_ff, rservo_ff, rdrive_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         gprop_ff  <= '0;
         ginteg_ff <= '0;
         gderiv_ff <= '0;
         limit_ff  <= LIMIT_RESET;
         rvalid_ff <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            filt_ff[a]  <= '0;
            integ_ff[a] <= '0;
            prev_ff[a]  <= '0;
         end
      end else begin
         center_ff <= center_in;
         gprop_ff  <= gprop_in;
         ginteg_ff <= ginteg_in;
         gderiv_ff <= gderiv_in;
         limit_ff  <= limit_in;
         rvalid_ff <= rvalid_in;
         if (cmd.err && valid_ff)   filt_ff[idx_ff]  <= fnew_ff;
         if (cmd.mul_d && valid_ff) integ_ff[idx_ff] <= imem_ff;
         if (cmd.mul_d && valid_ff) prev_ff[idx_ff]  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff    <= axis_in;
      stick_ff   <= stick_in;
      valid_ff   <= valid_in;
      idx_ff     <= idx_in;
      u5_ff      <= u5_in;
      u3_ff      <= u3_in;
      prod_ff    <= prod_in;
      fnew_ff    <= fnew_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      imem_ff    <= imem_in;
      pp_ff      <= pp_in;
      drive_ff   <= drive_in;
      raxis_ff   <= raxis_in;
      rdrive_ff  <= rdrive_in;
      rservo_ff  <= rservo_in;
      rmirror_ff <= rmirror_in;
   end

endmodule

@@ hdl/three_axis_rate_pid_mixer_core.sv @@
// Top level of the three-axis rate PID mixer: sequencer plus datapath.
// Depends on tarpm_pkg, tarpm_ctrl and tarpm_datapath.
//
//   channel   direction   handshake              payload
//   req_      in          req_tvalid/req_tready  tdata {lc,stick,gyro}, tuser axis_sel
//   rsp_      out         rsp_tvalid/rsp_tready  tdata {mirror,servo,drive}, tuser axis
//   csr_      in          csr_wen                csr_index, csr_wdata
//
// Once a request is accepted, req_tready stays low until its final step ends:
// the single shared multiplier serves two reciprocal divides and three gain
// products in turn, with the error step between them and the sum step after.
// Reset is synchronous; clears per-axis state and rsp_tvalid, restores the CSRs.
// The result waits in an output register; the next request is taken meanwhile
// and holds in its last step until the previous result is taken.
module three_axis_rate_pid_mixer_core import tarpm_pkg::*; #(
   parameter int AXES = TARPM_AXES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] gyro_rate, [27:16] stick_pulse, [43:28] level_correction, zero above
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // [1:0] axis_sel
   input  logic [AXIS_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] pid_drive, [28:16] servo_pulse, [41:29] mirror_pulse, zero above
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] axis_out
   output logic [AXIS_W-1:0]      rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   tarpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tarpm_datapath #(
      .AXES (AXES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a request is in progress");

   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.fin))
      else $error("result raised without a final step");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.div5, cmd.div3, cmd.err, cmd.mul_i,
                cmd.mul_p, cmd.mul_d, cmd.sum, cmd.fin}))
      else $error("more than one datapath step at once");

endmodule
